// ===== rtl/tifp_pkg.sv =====
`default_nettype none
package tifp_pkg;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  localparam logic [1:0] RADIX_SDEC = 2'd0;
  localparam logic [1:0] RADIX_UDEC = 2'd1;
  localparam logic [1:0] RADIX_HEX  = 2'd2;
  localparam logic [1:0] RADIX_OCT  = 2'd3;

  localparam logic [1:0] LEN_INT   = 2'd0;
  localparam logic [1:0] LEN_SHORT = 2'd1;
  localparam logic [1:0] LEN_LONG  = 2'd2;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_RADIX  = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef struct packed {
    logic [1:0] radix;
    logic [1:0] length;
  } cfg_t;

  typedef struct packed {
    logic       digit_ok;
    logic [3:0] digit;
    logic       is_sign;
    logic       is_neg;
    logic       blank_or_nul;
  } char_info_t;

endpackage
`default_nettype wire

// ===== rtl/tifp_classify.sv =====
`default_nettype none
module tifp_classify (
  input  wire logic [7:0]           ch,
  input  wire logic [1:0]           radix,
  output tifp_pkg::char_info_t      info
);

  logic [7:0] dec_off;
  logic [7:0] lo_off;
  logic [7:0] up_off;

  always_comb begin
    dec_off = ch - tifp_pkg::CH_ZERO;
    lo_off  = ch - tifp_pkg::CH_LA + tifp_pkg::HEX_TEN;
    up_off  = ch - tifp_pkg::CH_UA + tifp_pkg::HEX_TEN;
    info = '0;
    case (radix)
      tifp_pkg::RADIX_OCT: begin
        if (ch >= tifp_pkg::CH_ZERO && ch <= tifp_pkg::CH_SEVEN) begin
          info.digit_ok = 1'b1;
          info.digit    = dec_off[3:0];
        end
      end
      tifp_pkg::RADIX_HEX: begin
        if (ch >= tifp_pkg::CH_ZERO && ch <= tifp_pkg::CH_NINE) begin
          info.digit_ok = 1'b1;
          info.digit    = dec_off[3:0];
        end else if (ch >= tifp_pkg::CH_LA && ch <= tifp_pkg::CH_LF_HEX) begin
          info.digit_ok = 1'b1;
          info.digit    = lo_off[3:0];
        end else if (ch >= tifp_pkg::CH_UA && ch <= tifp_pkg::CH_UF) begin
          info.digit_ok = 1'b1;
          info.digit    = up_off[3:0];
        end
      end
      default: begin
        if (ch >= tifp_pkg::CH_ZERO && ch <= tifp_pkg::CH_NINE) begin
          info.digit_ok = 1'b1;
          info.digit    = dec_off[3:0];
        end
        info.is_sign = (ch == tifp_pkg::CH_PLUS) || (ch == tifp_pkg::CH_MINUS);
      end
    endcase
    info.is_neg       = (ch == tifp_pkg::CH_MINUS);
    info.blank_or_nul = (ch == tifp_pkg::CH_NUL) || (ch == tifp_pkg::CH_SPACE) ||
                        (ch == tifp_pkg::CH_TAB) || (ch == tifp_pkg::CH_LF);
  end

endmodule
`default_nettype wire

// ===== rtl/tifp_fsm.sv =====
`default_nettype none
module tifp_fsm (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_en,
  input  wire tifp_pkg::char_info_t info,
  input  wire tifp_pkg::cfg_t       cfg,
  output logic                      res_vld,
  output logic [63:0]               res_value,
  output logic                      res_fail
);

  tifp_pkg::phase_t phase_r, phase_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic             neg_r, neg_nxt;
  logic             seen_r, seen_nxt;

  logic [63:0] scaled;
  logic [63:0] signed_val;
  logic        sext;
  logic        fail_cur;

  always_comb begin
    case (cfg.radix)
      tifp_pkg::RADIX_HEX: scaled = {acc_r[59:0], 4'b0};
      tifp_pkg::RADIX_OCT: scaled = {acc_r[60:0], 3'b0};
      default:             scaled = {acc_r[60:0], 3'b0} + {acc_r[62:0], 1'b0};
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    seen_nxt  = seen_r;
    case (phase_r)
      tifp_pkg::PH_SIGN, tifp_pkg::PH_DIGITS: begin
        if (info.digit_ok) begin
          acc_nxt   = scaled + {60'b0, info.digit};
          seen_nxt  = 1'b1;
          phase_nxt = tifp_pkg::PH_DIGITS;
        end else begin
          acc_nxt   = '0;
          seen_nxt  = 1'b0;
          neg_nxt   = info.is_sign & info.is_neg;
          phase_nxt = info.is_sign ? tifp_pkg::PH_SIGN : tifp_pkg::PH_SKIP;
        end
      end
      default: begin
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        seen_nxt  = 1'b0;
        phase_nxt = tifp_pkg::PH_SKIP;
        if (!info.blank_or_nul) begin
          if (info.digit_ok) begin
            acc_nxt   = {60'b0, info.digit};
            seen_nxt  = 1'b1;
            phase_nxt = tifp_pkg::PH_DIGITS;
          end else if (info.is_sign) begin
            neg_nxt   = info.is_neg;
            phase_nxt = tifp_pkg::PH_SIGN;
          end
        end
      end
    endcase
  end

  // result
  always_comb begin
    signed_val = neg_r ? (64'd0 - acc_r) : acc_r;
    sext       = (cfg.radix == tifp_pkg::RADIX_SDEC);
    fail_cur   = !((phase_r == tifp_pkg::PH_DIGITS) && seen_r);
    case (phase_r)
      tifp_pkg::PH_SIGN, tifp_pkg::PH_DIGITS: begin
        res_vld  = !info.digit_ok;
        res_fail = fail_cur;
      end
      default: begin
        res_vld  = !info.blank_or_nul && !info.digit_ok && !info.is_sign;
        res_fail = 1'b1;
      end
    endcase
    case (cfg.length)
      tifp_pkg::LEN_INT:
        res_value = {{32{sext & signed_val[31]}}, signed_val[31:0]};
      tifp_pkg::LEN_SHORT:
        res_value = {{48{sext & signed_val[15]}}, signed_val[15:0]};
      default:
        res_value = signed_val;
    endcase
    if (res_fail) begin
      res_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tifp_pkg::PH_SKIP;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      seen_r  <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/text_to_integer_field_parser_core.sv =====
`default_nettype none
// path: input register, then field step, then output register at the end of each field
// throughput: one character per cycle through the field step between the input register and
// the result register, while the result register is free or being drained
// reset: synchronous active-low rst_n clears the parser state, both valid flags and the
// radix and length registers
module text_to_integer_field_parser_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // [7:0] ch
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [63:0]                          out_tdata,  // [63:0] value
  output logic                                 out_tuser,  // [0] fail
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [tifp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                     cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);

  tifp_pkg::cfg_t       cfg_r;
  tifp_pkg::char_info_t info;

  logic [7:0]  ch_r;
  logic        in_vld_r;
  logic        out_vld_r;
  logic [63:0] value_r;
  logic        fail_r;
  logic        step;
  logic        res_vld;
  logic [63:0] res_value;
  logic        res_fail;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        tifp_pkg::REG_RADIX:  cfg_r.radix  <= cfg_pwdata[1:0];
        tifp_pkg::REG_LENGTH: cfg_r.length <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      tifp_pkg::REG_RADIX:  cfg_prdata = {30'b0, cfg_r.radix};
      tifp_pkg::REG_LENGTH: cfg_prdata = {30'b0, cfg_r.length};
      default:              cfg_prdata = '0;
    endcase
  end

  assign step       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready  = !in_vld_r || step;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = value_r;
  assign out_tuser  = fail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ch_r <= in_tdata;
    end
  end

  tifp_classify u_classify (
    .ch    (ch_r),
    .radix (cfg_r.radix),
    .info  (info)
  );

  tifp_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step),
    .info      (info),
    .cfg       (cfg_r),
    .res_vld   (res_vld),
    .res_value (res_value),
    .res_fail  (res_fail)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_vld) begin
      value_r <= res_value;
      fail_r  <= res_fail;
    end
  end

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 64'd0))
    else $error("failed field carries a nonzero value");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !out_vld_r) |=> (!in_vld_r || $past(in_tvalid && in_tready)))
    else $error("buffered character not processed with output free");

  a_short_zext: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && cfg_r.length == tifp_pkg::LEN_SHORT &&
     cfg_r.radix != tifp_pkg::RADIX_SDEC) |-> (out_tdata[63:16] == 48'd0))
    else $error("short unsigned result not zero-extended");
`endif

endmodule
`default_nettype wire
